// File: src/lmeds_pkg.sv
// ----------------------------------------------------------------------------
// lmeds_pkg
// Shared constants and types for the line model score unit.
// ----------------------------------------------------------------------------
package lmeds_pkg;
    localparam int MAX_POINTS = 1024;
    localparam int DIST_BITS  = 16;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int SQ_BITS    = 2 * DIST_BITS;
    localparam int SEL_BITS   = 10;

    localparam logic [0:0] CFG_THRESHOLD  = 1'd0;
    localparam logic [0:0] CFG_MIN_POINTS = 1'd1;

    typedef struct packed {
        logic                last;
        logic [SQ_BITS-1:0]  sq;
        logic                keep;
        logic [SEL_BITS-1:0] first_idx;
        logic [SEL_BITS-1:0] second_idx;
    } word_t;
endpackage

// File: src/lmeds_front.sv
// ----------------------------------------------------------------------------
// lmeds_front
// Accept point words, square the distance and classify against the threshold.
// ----------------------------------------------------------------------------
module lmeds_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [lmeds_pkg::DIST_BITS-1:0]     thr,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lmeds_pkg::DIST_BITS-1:0]     point_dist,
    input  logic                                last,
    input  logic [lmeds_pkg::SEL_BITS-1:0]      idx_a,
    input  logic [lmeds_pkg::SEL_BITS-1:0]      idx_b,
    output logic                                out_valid,
    input  logic                                out_ready,
    output lmeds_pkg::word_t                    out_word
);
    logic                              s1_valid_reg;
    logic [lmeds_pkg::DIST_BITS-1:0]   s1_dist_reg;
    logic                              s1_last_reg;
    logic [lmeds_pkg::SEL_BITS-1:0]    s1_a_reg, s1_b_reg;
    logic [lmeds_pkg::SQ_BITS-1:0]     thr_sq_reg;
    logic                              s2_valid_reg;
    lmeds_pkg::word_t                  s2_word_reg;
    logic [lmeds_pkg::SQ_BITS-1:0]     sq;
    logic                              adv2, adv1;

    assign adv2     = !s2_valid_reg || out_ready;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;
    assign sq       = lmeds_pkg::SQ_BITS'(s1_dist_reg) * lmeds_pkg::SQ_BITS'(s1_dist_reg);
    assign out_valid = s2_valid_reg;
    assign out_word  = s2_word_reg;

    always_ff @(posedge aclk) begin
        thr_sq_reg <= lmeds_pkg::SQ_BITS'(thr) * lmeds_pkg::SQ_BITS'(thr);
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (adv1) s1_valid_reg <= in_valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
        end
        if (adv1 && in_valid) begin
            s1_dist_reg <= point_dist;
            s1_last_reg <= last;
            s1_a_reg    <= idx_a;
            s1_b_reg    <= idx_b;
        end
        if (adv2 && s1_valid_reg) begin
            s2_word_reg.sq         <= sq;
            s2_word_reg.keep       <= sq < thr_sq_reg;
            s2_word_reg.last       <= s1_last_reg;
            s2_word_reg.first_idx  <= s1_a_reg;
            s2_word_reg.second_idx <= s1_b_reg;
        end
    end
endmodule

// File: src/lmeds_queue.sv
// ----------------------------------------------------------------------------
// lmeds_queue
// Four-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module lmeds_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  lmeds_pkg::word_t in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output lmeds_pkg::word_t out_word
);
    lmeds_pkg::word_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 3'd4;
    assign out_valid = cnt_reg != 3'd0;
    assign out_word  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_word;
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
        end
    end
endmodule

// File: src/lmeds_back.sv
// ----------------------------------------------------------------------------
// lmeds_back
// Store inlier squares, select the median by rank counting, divide, report.
// ----------------------------------------------------------------------------
module lmeds_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [lmeds_pkg::CNT_BITS-1:0]      min_pts,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  lmeds_pkg::word_t                    in_word,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_accepted,
    output logic [lmeds_pkg::SQ_BITS-1:0]       m_scale,
    output logic [lmeds_pkg::CNT_BITS-1:0]      m_inliers,
    output logic [lmeds_pkg::SEL_BITS-1:0]      m_first,
    output logic [lmeds_pkg::SEL_BITS-1:0]      m_second
);
    localparam int SQ = lmeds_pkg::SQ_BITS;
    localparam int CB = lmeds_pkg::CNT_BITS;
    localparam int IB = lmeds_pkg::IDX_BITS;
    localparam int SEL_W = lmeds_pkg::SEL_BITS;

    typedef enum logic [2:0] {
        ST_LOAD, ST_OUTER, ST_INNER, ST_DIV, ST_OUT
    } state_t;

    logic [SQ-1:0] mem [lmeds_pkg::MAX_POINTS];
    logic [SQ-1:0] rd_reg;
    state_t        state_reg;
    logic [CB-1:0] inl_reg, pts_reg, i_reg, j_reg, less_reg, leq_reg;
    logic [SQ-1:0] cand_reg, lo_reg, hi_reg;
    logic          have_lo_reg, have_hi_reg, acc_reg, rd_ok_reg;
    logic [SEL_W-1:0] fa_reg, fb_reg;
    logic [CB-1:0] k_lo, k_hi;
    logic [SQ:0]   rem_reg;
    logic [SQ-1:0] quo_reg, dvd_reg;
    logic [5:0]    bit_reg;
    logic          m_valid_reg;
    logic [SQ:0]   sum;
    logic [SQ:0]   trial;
    logic [CB-1:0] less_n, leq_n;
    logic          take;

    assign in_ready = state_reg == ST_LOAD;
    assign take     = in_valid && in_ready;
    assign m_valid  = m_valid_reg;
    assign k_lo     = (inl_reg - CB'(1)) >> 1;
    assign k_hi     = inl_reg >> 1;
    assign sum      = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign trial    = {rem_reg[SQ-1:0], dvd_reg[SQ-1]};
    assign less_n   = less_reg + CB'(rd_ok_reg && rd_reg < cand_reg);
    assign leq_n    = leq_reg + CB'(rd_ok_reg && rd_reg <= cand_reg);

    always_ff @(posedge aclk) begin
        rd_reg    <= mem[j_reg[IB-1:0]];
        if (take && in_word.keep && !pts_reg[IB])
            mem[inl_reg[IB-1:0]] <= in_word.sq;
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            inl_reg     <= '0;
            pts_reg     <= '0;
            m_valid_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (take) begin
                        if (!pts_reg[IB]) begin
                            pts_reg <= pts_reg + CB'(1);
                            if (in_word.keep) inl_reg <= inl_reg + CB'(1);
                        end
                        if (in_word.last) begin
                            fa_reg <= in_word.first_idx;
                            fb_reg <= in_word.second_idx;
                            i_reg  <= '0;
                            have_lo_reg <= 1'b0;
                            have_hi_reg <= 1'b0;
                            state_reg <= ST_OUTER;
                        end
                    end
                end
                ST_OUTER: begin
                    // fetch candidate i, then scan all entries
                    acc_reg <= (pts_reg >= min_pts) && (inl_reg > min_pts);
                    if (!((pts_reg >= min_pts) && (inl_reg > min_pts))
                        || i_reg == inl_reg || (have_lo_reg && have_hi_reg)) begin
                        dvd_reg   <= (have_lo_reg && have_hi_reg) ? sum[SQ:1] : '0;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        bit_reg   <= 6'(SQ);
                        state_reg <= ST_DIV;
                    end else begin
                        j_reg     <= i_reg;
                        rd_ok_reg <= 1'b0;
                        less_reg  <= '0;
                        leq_reg   <= '0;
                        state_reg <= ST_INNER;
                    end
                end
                ST_INNER: begin
                    if (j_reg == i_reg && !rd_ok_reg) begin
                        // first cycle: address i issued
                        j_reg     <= '0;
                        rd_ok_reg <= 1'b1;
                        less_reg  <= CB'(1);
                    end else if (less_reg == CB'(1) && leq_reg == '0 && j_reg == '0
                                 && rd_ok_reg) begin
                        cand_reg <= rd_reg;
                        less_reg <= '0;
                        leq_reg  <= '0;
                        j_reg    <= CB'(1);
                        rd_ok_reg <= 1'b1;
                    end else begin
                        less_reg  <= less_n;
                        leq_reg   <= leq_n;
                        rd_ok_reg <= j_reg < inl_reg;
                        if (j_reg <= inl_reg) j_reg <= j_reg + CB'(1);
                        if (j_reg > inl_reg) begin
                            if (less_reg <= k_lo && k_lo < leq_reg) begin
                                lo_reg <= cand_reg;
                                have_lo_reg <= 1'b1;
                            end
                            if (less_reg <= k_hi && k_hi < leq_reg) begin
                                hi_reg <= cand_reg;
                                have_hi_reg <= 1'b1;
                            end
                            i_reg     <= i_reg + CB'(1);
                            state_reg <= ST_OUTER;
                        end
                    end
                end
                ST_DIV: begin
                    if (bit_reg == '0) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_OUT;
                    end else begin
                        dvd_reg <= dvd_reg << 1;
                        bit_reg <= bit_reg - 6'd1;
                        if (trial >= {{(SQ+1-CB){1'b0}}, inl_reg} && inl_reg != '0) begin
                            rem_reg <= trial - {{(SQ+1-CB){1'b0}}, inl_reg};
                            quo_reg <= {quo_reg[SQ-2:0], 1'b1};
                        end else begin
                            rem_reg <= trial;
                            quo_reg <= {quo_reg[SQ-2:0], 1'b0};
                        end
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        inl_reg     <= '0;
                        pts_reg     <= '0;
                        state_reg   <= ST_LOAD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign m_accepted = acc_reg;
    assign m_scale    = acc_reg ? quo_reg : '0;
    assign m_inliers  = inl_reg;
    assign m_first    = acc_reg ? fa_reg : '0;
    assign m_second   = acc_reg ? fb_reg : '0;
endmodule

// File: src/lmeds_line_model_score_unit.sv
// ----------------------------------------------------------------------------
// lmeds_line_model_score_unit
// Least-median-of-squares score of one candidate line model.
// ----------------------------------------------------------------------------
// One input word per point: s_tdata carries the distance and both sample
// indexes, s_tlast closes the event. Points stream in at one per cycle while
// s_tready is high; the front squares and classifies them and a four-word queue
// feeds the back, which writes inlier squares into a 1024-entry memory.
// After the last point the back selects the median by counting ranks of
// each candidate over the memory (at most n candidates for n inliers, one
// memory read port), then runs a 32-step restoring divider. A rejected
// model skips the selection and goes straight to the divider.
// One result word leaves on m_ when the event closes; the next event waits
// until it is taken. Registers are to be written on the cfg channel only
// while idle; the block itself does not enforce this.
// Synchronous active-low reset clears counters and state; the square memory
// needs no clearing. When the receiver stalls the result holds and input
// backs up through the queue.
// ----------------------------------------------------------------------------
module lmeds_line_model_score_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // point_distance, first_sample_index, second_sample_index
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // model_accepted, model_scale, inlier_total,
                                   // model_first_index, model_second_index
    output logic        m_tlast
);
    logic [15:0] thr_reg;
    logic [10:0] minp_reg;
    logic        f_valid, f_ready, q_valid, q_ready;
    lmeds_pkg::word_t f_word, q_word;
    logic        acc;
    logic [31:0] scale;
    logic [10:0] inl;
    logic [9:0]  fa, fb;

    assign cfg_ready = 1'b1;
    assign m_tlast   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= '0;
            minp_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lmeds_pkg::CFG_THRESHOLD:  thr_reg  <= cfg_data;
                lmeds_pkg::CFG_MIN_POINTS: minp_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    lmeds_front u_front (
        .aclk, .aresetn, .thr(thr_reg),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .point_dist(s_tdata[15:0]), .last(s_tlast),
        .idx_a(s_tdata[25:16]), .idx_b(s_tdata[35:26]),
        .out_valid(f_valid), .out_ready(f_ready), .out_word(f_word)
    );

    lmeds_queue u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
        .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word)
    );

    lmeds_back u_back (
        .aclk, .aresetn, .min_pts(minp_reg),
        .in_valid(q_valid), .in_ready(q_ready), .in_word(q_word),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_accepted(acc), .m_scale(scale), .m_inliers(inl),
        .m_first(fa), .m_second(fb)
    );

    assign m_tdata = {fb, fa, inl, scale, acc};

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_rej: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
        else $error("rejected model with nonzero scale");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[43:33] <= 11'd1024)
        else $error("inlier count overflow");
endmodule
